// ----- src/qcd_pkg.sv -----
// shared types, constants and reference tables for the quadrature correlation demodulator
// no dependencies
package qcd_pkg;

    localparam int SPS_DEFAULT = 20;
    localparam int SPS_MIN     = 10;
    localparam int SPS_MAX     = 30;
    localparam int CARRIER_LEN = 10;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 11;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = 32;
    localparam int INDEX_W  = 5;
    localparam int PHASE_W  = 4;
    localparam int COUNT_W  = 16;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CARRIER_LEN - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [PHASE_W-1:0]         t_phase;
    typedef logic [COUNT_W-1:0]         t_count;

    typedef struct packed {
        logic   advance;
        logic   last;
        t_phase phase;
    } t_mac_ctl;

    function automatic t_coef cos_coef(input t_phase p);
        t_coef c;
        case (p)
            4'd0:    c = 11'sd1000;
            4'd1:    c = 11'sd809;
            4'd2:    c = 11'sd309;
            4'd3:    c = -11'sd309;
            4'd4:    c = -11'sd809;
            4'd5:    c = -11'sd1000;
            4'd6:    c = -11'sd809;
            4'd7:    c = -11'sd309;
            4'd8:    c = 11'sd309;
            4'd9:    c = 11'sd809;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_coef sin_coef(input t_phase p);
        t_coef c;
        case (p)
            4'd0:    c = 11'sd0;
            4'd1:    c = 11'sd588;
            4'd2:    c = 11'sd951;
            4'd3:    c = 11'sd951;
            4'd4:    c = 11'sd588;
            4'd5:    c = 11'sd0;
            4'd6:    c = -11'sd588;
            4'd7:    c = -11'sd951;
            4'd8:    c = -11'sd951;
            4'd9:    c = -11'sd588;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- src/qcd_mac.sv -----
// cosine and sine multiply-accumulate with per-symbol clear
// depends on qcd_pkg
module qcd_mac import qcd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_ctl i_ctl,
    input  t_sample  i_sample,
    output t_acc     o_sum_i,
    output t_acc     o_sum_q
);

    t_acc r_acc_i;
    t_acc r_acc_q;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_q;

    always_comb begin
        prod_i  = PROD_W'(i_sample) * PROD_W'(cos_coef(i_ctl.phase));
        prod_q  = PROD_W'(i_sample) * PROD_W'(sin_coef(i_ctl.phase));
        o_sum_i = r_acc_i + ACC_W'(prod_i);
        o_sum_q = r_acc_q + ACC_W'(prod_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (i_ctl.advance) begin
            r_acc_i <= i_ctl.last ? '0 : o_sum_i;
            r_acc_q <= i_ctl.last ? '0 : o_sum_q;
        end
    end

endmodule

// ----- src/qcd_decide.sv -----
// bit decision, error check and saturating error counter
// depends on qcd_pkg
module qcd_decide import qcd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_update,
    input  t_acc   i_sum_i,
    input  t_acc   i_sum_q,
    input  logic   i_ref_bit,
    output logic   o_bit,
    output logic   o_error,
    output t_count o_total
);

    t_count r_count;

    always_comb begin
        if (i_sum_i > i_sum_q) begin
            o_bit = 1'b1;
        end else if (i_sum_i < i_sum_q) begin
            o_bit = 1'b0;
        end else begin
            o_bit = !(i_sum_i > 0);
        end
        o_error = o_bit != i_ref_bit;
        o_total = (o_error && r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_update) begin
            r_count <= o_total;
        end
    end

endmodule

// ----- src/quadrature_correlation_demodulator.sv -----
// top level: input register, symbol position counters, mac, decision and result register
// depends on qcd_pkg, qcd_mac, qcd_decide
//
// usage
//   input channel: i_valid / o_stall carry one signed 16-bit sample and the
//   reference bit of its symbol; a transfer happens when i_valid is high and
//   o_stall is low. the reference bit matters only on the last sample of a symbol.
//   output channel: o_valid / i_stall carry one result per symbol of
//   SAMPLES_PER_SYMBOL samples: decided bit, error flag, running error total
//   and the final cosine and sine sums.
//   throughput: one sample per cycle while o_stall is low. samples go through an input register and
//   one multiply-accumulate step into the accumulators and the result register.
//   result: a symbol's result is loaded into the result register when its last
//   sample leaves the input register through the final multiply-accumulate step.
//   stall: a waiting result holds its outputs; samples keep flowing into the
//   accumulators, and o_stall rises only when the last sample of the following
//   symbol reaches the input register while the previous result is still held.
//   reset: synchronous, active low; clears the position counters, sums, error
//   total and both valid flags.
//
module quadrature_correlation_demodulator import qcd_pkg::*; #(
    parameter int SAMPLES_PER_SYMBOL = SPS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_sample,
    input  logic                i_ref_bit,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_decided_bit,
    output logic                o_bit_error,
    output logic [15:0]         o_error_total,
    output logic signed [31:0]  o_corr_i,
    output logic signed [31:0]  o_corr_q
);

    localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(SAMPLES_PER_SYMBOL - 1);

    logic [INDEX_W-1:0] r_index;
    t_phase             r_phase;
    logic               r_s1_valid;
    logic               r_s1_last;
    t_phase             r_s1_phase;
    t_sample            r_s1_sample;
    logic               r_s1_ref;

    logic               r_o_valid;
    logic               r_o_bit;
    logic               r_o_err;
    t_count             r_o_total;
    t_acc               r_o_i;
    t_acc               r_o_q;

    logic               accept;
    logic               s1_move;
    logic               idx_last;
    t_mac_ctl           mac_ctl;
    t_acc               sum_i;
    t_acc               sum_q;
    logic               dec_bit;
    logic               dec_err;
    t_count             dec_total;

    always_comb begin
        s1_move          = r_s1_valid && !(r_s1_last && r_o_valid && i_stall);
        o_stall          = r_s1_valid && !s1_move;
        accept           = i_valid && !o_stall;
        idx_last         = r_index >= INDEX_LAST;
        mac_ctl.advance  = s1_move;
        mac_ctl.last     = r_s1_last;
        mac_ctl.phase    = r_s1_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index    <= '0;
            r_phase    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_index    <= idx_last ? '0 : r_index + 1'b1;
                r_phase    <= (idx_last || r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last   <= idx_last;
            r_s1_phase  <= r_phase;
            r_s1_sample <= i_sample;
            r_s1_ref    <= i_ref_bit;
        end
    end

    qcd_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (r_s1_sample),
        .o_sum_i  (sum_i),
        .o_sum_q  (sum_q)
    );

    qcd_decide u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_update  (s1_move && r_s1_last),
        .i_sum_i   (sum_i),
        .i_sum_q   (sum_q),
        .i_ref_bit (r_s1_ref),
        .o_bit     (dec_bit),
        .o_error   (dec_err),
        .o_total   (dec_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move && r_s1_last) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_last) begin
            r_o_bit   <= dec_bit;
            r_o_err   <= dec_err;
            r_o_total <= dec_total;
            r_o_i     <= sum_i;
            r_o_q     <= sum_q;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_decided_bit = r_o_bit;
    assign o_bit_error   = r_o_err;
    assign o_error_total = r_o_total;
    assign o_corr_i      = r_o_i;
    assign o_corr_q      = r_o_q;

endmodule

// ----- src/qcd_checks.sv -----
// port-level checks for quadrature_correlation_demodulator, bound to the top level
// depends on quadrature_correlation_demodulator
module qcd_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_decided_bit,
    input logic               o_bit_error,
    input logic [15:0]        o_error_total,
    input logic signed [31:0] o_corr_i,
    input logic signed [31:0] o_corr_q
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_error_total) && $stable(o_corr_i)
            && $stable(o_corr_q) && $stable(o_decided_bit))
        else $error("stalled result changed");

    a_decision_matches_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_corr_i != o_corr_q) |-> o_decided_bit == (o_corr_i > o_corr_q))
        else $error("decided bit disagrees with sums");

    a_error_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bit_error |-> o_error_total != 16'd0)
        else $error("error flagged but total is zero");

endmodule

bind quadrature_correlation_demodulator qcd_checks u_qcd_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_decided_bit (o_decided_bit),
    .o_bit_error   (o_bit_error),
    .o_error_total (o_error_total),
    .o_corr_i      (o_corr_i),
    .o_corr_q      (o_corr_q)
);

// ----- tb/testbench.sv -----
// self-checking testbench for quadrature_correlation_demodulator: directed symbol table,
// random symbols with idle gaps and stalls, and a run of symbols that are always errors
// depends on qcd_pkg and the demodulator rtl in src
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qcd_pkg::*;

    localparam int SPS            = SPS_DEFAULT;
    localparam int LIMIT          = 3_000_000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_SYMBOLS = 60;
    localparam int TAIL_SYMBOLS   = 10;

    localparam int COS_MILLI [CARRIER_LEN] = '{
        1000, 809, 309, -309, -809, -1000, -809, -309, 309, 809
    };
    localparam int SIN_MILLI [CARRIER_LEN] = '{
        0, 588, 951, 951, 588, 0, -588, -951, -951, -588
    };

    typedef enum int {
        SYM_FULL, SYM_EXTREME, SYM_TIE, SYM_FLAT, SYM_TONE, SYM_SMALL
    } t_sym_kind;

    typedef struct packed {
        logic   decided;
        logic   err;
        t_count total;
        t_acc   ci;
        t_acc   cq;
    } t_symbol_result;

    typedef struct {
        t_sample        samples [SPS];
        logic           ref_bit;
        t_symbol_result result;
    } t_directed_symbol;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_sample i_sample;
    logic    i_ref_bit;
    logic    o_valid;
    logic    i_stall;
    logic    o_decided_bit;
    logic    o_bit_error;
    t_count  o_error_total;
    t_acc    o_corr_i;
    t_acc    o_corr_q;

    quadrature_correlation_demodulator #(.SAMPLES_PER_SYMBOL(SPS)) dut (.*);

    // zero symbol ties at zero, max/min samples on the cosine peaks, positive tie
    t_directed_symbol directed_symbols [3] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0,
          '{1'b1, 1'b1, 16'd1, 32'sd0, 32'sd0}},
        '{'{32767, 0, 0, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
          '{1'b1, 1'b0, 16'd1, 32'sd65535000, 32'sd0}},
        '{'{321, 0, 500, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0,
          '{1'b0, 1'b0, 16'd1, 32'sd475500, 32'sd475500}}
    };

    t_symbol_result expected_symbols [$];
    int unsigned    sym_pos;
    t_acc           sum_i;
    t_acc           sum_q;
    t_count         err_total;
    int             fail_count  = 0;
    int             cycle_count = 0;
    bit             idle_on     = 0;

    function automatic logic advance_correlator(input t_sample s, input logic ref_bit,
                                                output t_symbol_result r);
        int   phase;
        logic bit_out;
        phase = sym_pos % CARRIER_LEN;
        sum_i = t_acc'(longint'(sum_i) + longint'(s) * COS_MILLI[phase]);
        sum_q = t_acc'(longint'(sum_q) + longint'(s) * SIN_MILLI[phase]);
        r = '0;
        if (sym_pos + 1 < SPS) begin
            sym_pos++;
            return 1'b0;
        end
        if (sum_i > sum_q)
            bit_out = 1'b1;
        else if (sum_i < sum_q)
            bit_out = 1'b0;
        else
            bit_out = !(sum_i > 0 && sum_q > 0);
        r.decided = bit_out;
        r.err     = (bit_out != ref_bit);
        if (r.err && err_total != COUNT_MAX)
            err_total++;
        r.total = err_total;
        r.ci    = sum_i;
        r.cq    = sum_q;
        sum_i   = '0;
        sum_q   = '0;
        sym_pos = 0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // entered and left just after a falling edge
    task automatic send_sample(input t_sample s, input logic ref_bit, input logic typed,
                               input t_symbol_result typed_result);
        t_symbol_result r;
        int             gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_sample  = s;
        i_ref_bit = ref_bit;
        do
            @(posedge i_clk);
        while (o_stall);
        if (advance_correlator(s, ref_bit, r))
            expected_symbols.push_back(typed ? typed_result : r);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid = 1'b0;
        while (expected_symbols.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_random_symbol();
        t_sample        smp [SPS];
        t_sym_kind      kind;
        t_symbol_result unused;
        int             k;
        int             c;
        int             amp;
        int             off;
        int             v;
        unused = '0;
        kind = t_sym_kind'($urandom_range(0, 5));
        foreach (smp[n])
            smp[n] = '0;
        case (kind)
            SYM_FULL: begin
                foreach (smp[n])
                    smp[n] = t_sample'($urandom_range(0, 65535));
            end
            SYM_EXTREME: begin
                foreach (smp[n]) begin
                    case ($urandom_range(0, 3))
                        0: smp[n] = 16'sh7fff;
                        1: smp[n] = 16'sh8000;
                        2: smp[n] = 16'sh0000;
                        default: smp[n] = 16'shffff;
                    endcase
                end
            end
            SYM_TIE: begin
                // a constant over a whole carrier period adds nothing to either sum
                k = $urandom_range(0, 130) - 65;
                c = $urandom_range(0, 400) - 200;
                foreach (smp[n])
                    smp[n] = t_sample'(c);
                smp[0] = t_sample'(321 * k + c);
                smp[2] = t_sample'(500 * k + c);
            end
            SYM_FLAT: begin
                c = $urandom_range(0, 65535);
                foreach (smp[n])
                    smp[n] = t_sample'(c);
            end
            SYM_TONE: begin
                amp = $urandom_range(0, 32767);
                if ($urandom_range(0, 1))
                    amp = -amp;
                off = $urandom_range(0, CARRIER_LEN - 1);
                foreach (smp[n]) begin
                    v = amp * COS_MILLI[(n + off) % CARRIER_LEN] / 1000
                        + int'($urandom_range(0, 200)) - 100;
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                    smp[n] = t_sample'(v);
                end
            end
            default: begin
                foreach (smp[n])
                    smp[n] = t_sample'($urandom_range(0, 200) - 100);
            end
        endcase
        foreach (smp[n])
            send_sample(smp[n], 1'($urandom_range(0, 1)), 1'b0, unused);
    endtask

    task automatic note_mismatch(input string field, input longint want, input longint got);
        fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAIL quadrature_correlation_demodulator");
            $finish;
        end
    end

    initial begin : receiver_stall
        int hold;
        int roll;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!idle_on) begin
                i_stall = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    i_stall = 1'b0;
                    hold    = $urandom_range(0, 8);
                end else if (roll < 90) begin
                    i_stall = 1'b1;
                    hold    = $urandom_range(0, 3);
                end else begin
                    i_stall = 1'b1;
                    hold    = $urandom_range(10, 50);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_symbol_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_symbols.size() == 0) begin
                fail_count++;
                $error("result transfer with no expected symbol waiting");
            end else begin
                want = expected_symbols.pop_front();
                if (o_decided_bit !== want.decided)
                    note_mismatch("decided_bit", want.decided, o_decided_bit);
                if (o_bit_error !== want.err)
                    note_mismatch("bit_error", want.err, o_bit_error);
                if (o_error_total !== want.total)
                    note_mismatch("error_total", want.total, o_error_total);
                if (o_corr_i !== want.ci)
                    note_mismatch("corr_i", $signed(want.ci), o_corr_i);
                if (o_corr_q !== want.cq)
                    note_mismatch("corr_q", $signed(want.cq), o_corr_q);
            end
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_sample  = '0;
        i_ref_bit = 1'b0;
        sym_pos   = 0;
        sum_i     = '0;
        sum_q     = '0;
        err_total = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_symbols[n]) begin
            for (int k = 0; k < SPS; k++)
                send_sample(directed_symbols[n].samples[k], directed_symbols[n].ref_bit,
                            k == SPS - 1, directed_symbols[n].result);
        end
        wait_for_results();

        repeat (RANDOM_SYMBOLS) begin
            idle_on = ($urandom_range(0, 4) != 0);
            send_random_symbol();
        end
        idle_on = 1'b0;
        wait_for_results();

        // zero symbols always decide 1, so a 0 reference is always an error
        repeat (4) begin
            for (int k = 0; k < SPS; k++)
                send_sample('0, 1'b0, 1'b0, '0);
        end
        wait_for_results();

        repeat (TAIL_SYMBOLS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_symbol();
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("PASS quadrature_correlation_demodulator");
        else
            $display("FAIL quadrature_correlation_demodulator");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/qcd_pkg.sv
src/qcd_mac.sv
src/qcd_decide.sv
src/quadrature_correlation_demodulator.sv
src/qcd_checks.sv
tb/testbench.sv
